// ===== sv/dms_pkg.sv =====
// Shared types and constants of the delta-modulation speech sequencer.
// No dependencies; used by the interfaces, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

  localparam int unsigned RomAddrBits = 12;
  localparam int unsigned RomDepth    = 1 << RomAddrBits;
  localparam int unsigned RomLenBits  = RomAddrBits + 1;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_WORD     = 8'b0000_0010,
    ST_CADDR_HI = 8'b0000_0100,
    ST_CADDR_LO = 8'b0000_1000,
    ST_BLOCK    = 8'b0001_0000,
    ST_CTRL     = 8'b0010_0000,
    ST_PLAY     = 8'b0100_0000,
    ST_END      = 8'b1000_0000
  } state_e;

  localparam logic [3:0] LevelMid = 4'd7;

  // Integrator step size, indexed by (row, column) delta codes.
  function automatic logic [1:0] inc_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [1:0] res;
    case ({row, col})
      4'b00_00, 4'b00_01: res = 2'd3;
      4'b00_10, 4'b00_11: res = 2'd1;
      4'b01_00, 4'b01_01: res = 2'd1;
      4'b01_10, 4'b01_11: res = 2'd0;
      4'b10_00, 4'b10_01: res = 2'd0;
      4'b10_10, 4'b10_11: res = 2'd1;
      4'b11_00, 4'b11_01: res = 2'd1;
      4'b11_10, 4'b11_11: res = 2'd3;
      default:            res = 2'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/dms_if.sv =====
// Valid/ready channel interfaces for the sequencer: input items and results.
// Depends on dms_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface dms_in_if import dms_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [1:0]             action;
  logic [RomAddrBits-1:0] load_address;
  logic [7:0]             load_byte;
  logic [5:0]             word_number;

  modport source (output valid, action, load_address, load_byte, word_number, input ready);
  modport sink   (input valid, action, load_address, load_byte, word_number, output ready);
endinterface

interface dms_out_if import dms_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [3:0] level;
  logic       busy_res;
  logic       finished;

  modport source (output valid, level, busy_res, finished, input ready);
  modport sink   (input valid, level, busy_res, finished, output ready);
endinterface

`default_nettype wire

// ===== sv/delta_modulation_speech_sequencer_top.sv =====
// Top level of the delta-modulation speech sequencer: phrase ROM plus sequencer.
// Depends on dms_pkg, dms_in_if / dms_out_if and dms_ram.
`timescale 1ns / 1ps
`default_nettype none

// The block holds a 4096 x 8 phrase ROM in a single-port synchronous RAM and
// a small set of sequencer registers. Input beats carry one of three actions:
// load writes one ROM byte, start clears the sequencer and latches a word
// number, tick advances one clock phase and yields one result beat (level,
// busy, finished); action code 3 is taken and dropped. Loads and starts follow
// each other back to back. An accepted tick reads the ROM at the registered
// fetch address; in its update cycle the read byte is folded into the
// sequencer registers and the output register is loaded. No beat is taken
// during that update cycle, so a tick must be through before the next beat
// is taken. A tick is taken only when the output register is empty or
// draining; loads and starts are taken while a result waits. rom_length
// gates ROM reads: an address at or past it reads as zero.
// The ROM has no reset and must be loaded before a word is played.
module delta_modulation_speech_sequencer_top import dms_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [RomLenBits-1:0] cfg_wdata_i,
  dms_in_if.sink                     item_i,
  dms_out_if.source                  result_o
);

  // ---------------------------------------------------------------------------
  // Sequencer registers
  // ---------------------------------------------------------------------------
  logic                   phase_one_q, phase_one_d;
  state_e                 state_q, state_d;
  logic [8:0]             block_q, block_d;
  logic [4:0]             offset_q, offset_d;
  logic [RomAddrBits-1:0] ctrl_addr_q, ctrl_addr_d;
  logic                   stop_q, stop_d;
  logic                   voiced_q, voiced_d;
  logic                   silence_q, silence_d;
  logic [6:0]             length_q, length_d;
  logic [1:0]             reload_q, reload_d;
  logic [1:0]             prev_delta_q, prev_delta_d;
  logic [3:0]             level_q, level_d;
  logic [RomAddrBits-1:0] fetch_addr_q, fetch_addr_d;
  logic                   busy_q, busy_d;
  logic [5:0]             word_q, word_d;
  logic                   c_off_q, c_off_d;
  logic                   c_quarter_q, c_quarter_d;
  logic                   c_repeat_q, c_repeat_d;
  logic                   c_length_q, c_length_d;

  logic [RomLenBits-1:0]  rom_len_q;
  logic                   exec_q;     // tick in its update cycle
  logic                   rd_zero_q;  // read address was past rom_length

  logic                   out_valid_q;
  logic [3:0]             out_level_q;
  logic                   out_busy_q;
  logic                   out_fin_q;

  // ---------------------------------------------------------------------------
  // Input handshake
  // ---------------------------------------------------------------------------
  logic       out_free;
  logic       in_acc;
  logic       acc_load;
  logic       acc_start;
  logic       acc_tick;
  logic [7:0] ram_rdata;
  logic [7:0] rom_byte;

  assign out_free = !out_valid_q || result_o.ready;

  // No beat during a tick's update cycle; ticks also need room at the output.
  assign item_i.ready = !exec_q && ((item_i.action != ACT_TICK) || out_free);

  assign in_acc    = item_i.valid && item_i.ready;
  assign acc_load  = in_acc && (item_i.action == ACT_LOAD);
  assign acc_start = in_acc && (item_i.action == ACT_START);
  assign acc_tick  = in_acc && (item_i.action == ACT_TICK);

  // ---------------------------------------------------------------------------
  // Phrase ROM: loads write, ticks read at the registered fetch address
  // ---------------------------------------------------------------------------
  dms_ram #(
    .WIDTH (8),
    .DEPTH (RomDepth)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (acc_load || acc_tick),
    .we_i    (acc_load),
    .addr_i  (acc_load ? item_i.load_address : fetch_addr_q),
    .wdata_i (item_i.load_byte),
    .rdata_o (ram_rdata)
  );

  assign rom_byte = rd_zero_q ? 8'd0 : ram_rdata;

  // ---------------------------------------------------------------------------
  // Next-state logic: start clears, tick update cycle runs one phase
  // ---------------------------------------------------------------------------
  always_comb begin : seq_comb
    logic [1:0] quarter;
    logic       pstart;
    logic       mirror;
    logic [1:0] sel;
    logic [1:0] delta;
    logic [1:0] old;
    logic [1:0] inc;
    logic       add;
    logic [3:0] lv;
    logic [4:0] sum;
    logic [4:0] addr_off;

    phase_one_d  = phase_one_q;
    state_d      = state_q;
    block_d      = block_q;
    offset_d     = offset_q;
    ctrl_addr_d  = ctrl_addr_q;
    stop_d       = stop_q;
    voiced_d     = voiced_q;
    silence_d    = silence_q;
    length_d     = length_q;
    reload_d     = reload_q;
    prev_delta_d = prev_delta_q;
    level_d      = level_q;
    fetch_addr_d = fetch_addr_q;
    busy_d       = busy_q;
    word_d       = word_q;
    c_off_d      = c_off_q;
    c_quarter_d  = c_quarter_q;
    c_repeat_d   = c_repeat_q;
    c_length_d   = c_length_q;

    quarter  = length_q[1:0];
    pstart   = (offset_q == 5'd0);
    mirror   = voiced_q && quarter[0];
    sel      = offset_q[1:0] ^ {2{mirror}};
    delta    = 2'(rom_byte >> {~sel, 1'b0});
    old      = ((quarter == 2'd0) && pstart) ? 2'd2 : prev_delta_q;
    inc      = 2'd0;
    add      = 1'b0;
    lv       = 4'd0;
    sum      = 5'd0;
    addr_off = 5'd0;

    if (acc_start) begin
      phase_one_d  = 1'b0;
      state_d      = ST_WORD;
      block_d      = '0;
      offset_d     = '0;
      ctrl_addr_d  = '0;
      stop_d       = 1'b0;
      voiced_d     = 1'b0;
      silence_d    = 1'b0;
      length_d     = '0;
      reload_d     = '0;
      prev_delta_d = '0;
      level_d      = LevelMid;
      fetch_addr_d = '0;
      busy_d       = 1'b0;
      word_d       = item_i.word_number;
      c_off_d      = 1'b0;
      c_quarter_d  = 1'b0;
      c_repeat_d   = 1'b0;
      c_length_d   = 1'b0;
    end else if (exec_q) begin
      if (phase_one_q) begin
        // Second phase: carry chain of offset and length counters.
        phase_one_d = 1'b0;
        c_off_d     = (offset_q == 5'h1F);
        c_quarter_d = c_off_d && (length_q[1:0] == 2'd3);
        c_repeat_d  = c_quarter_d && (length_q[3:2] == 2'd3);
        c_length_d  = c_repeat_d && (length_q == 7'h7F);
      end else begin
        phase_one_d = 1'b1;
        case (state_q)
          ST_IDLE: begin
            level_d = LevelMid;
            busy_d  = 1'b0;
          end
          ST_WORD: begin
            block_d      = {5'd0, word_q[5:2]};
            offset_d     = {word_q[1:0], 3'd0};
            fetch_addr_d = {5'd0, word_q[5:2], word_q[1:0], 1'b0};
            level_d      = LevelMid;
            busy_d       = 1'b1;
            state_d      = ST_CADDR_HI;
          end
          ST_CADDR_HI: begin
            ctrl_addr_d  = {rom_byte, 4'd0};
            offset_d     = offset_q + 5'd4;
            fetch_addr_d = {block_q, offset_d[4:2]};
            level_d      = LevelMid;
            state_d      = ST_CADDR_LO;
          end
          ST_CADDR_LO: begin
            ctrl_addr_d  = {ctrl_addr_q[11:4], rom_byte[7:4]};
            fetch_addr_d = ctrl_addr_d;
            level_d      = LevelMid;
            state_d      = ST_BLOCK;
          end
          ST_BLOCK: begin
            block_d      = {rom_byte, 1'b0};
            offset_d     = '0;
            ctrl_addr_d  = ctrl_addr_q + 12'd1;
            fetch_addr_d = ctrl_addr_d;
            level_d      = LevelMid;
            state_d      = ST_CTRL;
          end
          ST_CTRL: begin
            stop_d       = rom_byte[7];
            voiced_d     = rom_byte[6];
            silence_d    = rom_byte[5];
            reload_d     = rom_byte[1:0];
            length_d     = {rom_byte[4:0], 2'd0};
            offset_d     = '0;
            ctrl_addr_d  = ctrl_addr_q + 12'd1;
            fetch_addr_d = {block_q, 3'd0};
            level_d      = LevelMid;
            state_d      = ST_PLAY;
          end
          ST_PLAY: begin
            // Delta decode; odd quarters of voiced frames run mirrored.
            if (!mirror) begin
              inc = inc_lookup(delta, old);
              add = delta[1];
            end else begin
              inc = inc_lookup(old, delta);
              add = !old[1];
            end
            if (mirror && pstart) begin
              inc = 2'd0;
            end
            prev_delta_d = delta;

            // Integrator, saturating at both ends via the complement trick.
            if (silence_q || (voiced_q && quarter[1])) begin
              level_d = LevelMid;
            end else begin
              lv = ((quarter == 2'd0) && pstart) ? LevelMid : level_q;
              if (!add) begin
                lv = ~lv;
              end
              sum = {1'b0, lv} + {3'd0, inc};
              lv  = sum[4] ? 4'hF : sum[3:0];
              if (!add) begin
                lv = ~lv;
              end
              level_d = lv;
            end

            offset_d = offset_q + 5'd1;
            if (c_off_q) begin
              offset_d = '0;
              length_d = length_q + 7'd1;
            end
            if (voiced_q && c_repeat_q) begin
              length_d = {length_d[6:4], reload_q, 2'd0};
              block_d  = block_q + 9'd1;
            end
            if (!voiced_q && c_off_q) begin
              block_d = block_q + 9'd1;
            end

            addr_off     = offset_d ^ {5{voiced_q && length_d[0]}};
            fetch_addr_d = {block_d, addr_off[4:2]};

            if (stop_q && c_length_q) begin
              state_d = ST_END;
            end else if (c_length_q) begin
              state_d      = ST_BLOCK;
              fetch_addr_d = ctrl_addr_q;
            end else begin
              state_d = ST_PLAY;
            end
          end
          default: begin
            level_d = LevelMid;
            state_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_one_q  <= 1'b0;
      state_q      <= ST_IDLE;
      block_q      <= '0;
      offset_q     <= '0;
      ctrl_addr_q  <= '0;
      stop_q       <= 1'b0;
      voiced_q     <= 1'b0;
      silence_q    <= 1'b0;
      length_q     <= '0;
      reload_q     <= '0;
      prev_delta_q <= '0;
      level_q      <= LevelMid;
      fetch_addr_q <= '0;
      busy_q       <= 1'b0;
      word_q       <= '0;
      c_off_q      <= 1'b0;
      c_quarter_q  <= 1'b0;
      c_repeat_q   <= 1'b0;
      c_length_q   <= 1'b0;
      rom_len_q    <= RomLenBits'(RomDepth);
      exec_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_one_q  <= phase_one_d;
      state_q      <= state_d;
      block_q      <= block_d;
      offset_q     <= offset_d;
      ctrl_addr_q  <= ctrl_addr_d;
      stop_q       <= stop_d;
      voiced_q     <= voiced_d;
      silence_q    <= silence_d;
      length_q     <= length_d;
      reload_q     <= reload_d;
      prev_delta_q <= prev_delta_d;
      level_q      <= level_d;
      fetch_addr_q <= fetch_addr_d;
      busy_q       <= busy_d;
      word_q       <= word_d;
      c_off_q      <= c_off_d;
      c_quarter_q  <= c_quarter_d;
      c_repeat_q   <= c_repeat_d;
      c_length_q   <= c_length_d;
      if (cfg_we_i) begin
        rom_len_q <= cfg_wdata_i;
      end
      exec_q <= acc_tick;
      if (exec_q) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (acc_tick) begin
      rd_zero_q <= ({1'b0, fetch_addr_q} >= rom_len_q);
    end
    if (exec_q) begin
      out_level_q <= level_d;
      out_busy_q  <= busy_d;
      out_fin_q   <= (state_d == ST_IDLE) && !busy_d;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.level    = out_level_q;
  assign result_o.busy_res = out_busy_q;
  assign result_o.finished = out_fin_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_tick_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_tick |=> exec_q)
    else $error("accepted tick did not enter its update cycle");

  a_exec_yields_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |=> out_valid_q)
    else $error("tick update cycle did not load a result beat");

  a_no_accept_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |-> !in_acc)
    else $error("beat accepted during a tick update cycle");

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q |-> !out_valid_q)
    else $error("result beat would be overwritten");

  a_finished_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_fin_q) |-> (out_level_q == LevelMid) && !out_busy_q)
    else $error("finished beat with non-idle level or busy set");

endmodule

`default_nettype wire

// ===== sv/dms_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for delta_modulation_speech_sequencer_top: ROM fill, word playback, result checks.
// Depends on dms_pkg, the dms_in_if / dms_out_if interfaces and the top level in sv/.
`timescale 1ns / 1ps

module tb;
  import dms_pkg::*;

  // One result beat of the sequencer, as predicted.
  typedef struct packed {
    logic [3:0] level;
    logic       busy;
    logic       finished;
  } dac_beat_t;

  // Tracks the sequencer beat by beat and holds the DAC beats still owed by the block.
  class speech_tracker;
    bit [7:0]            rom_img [RomDepth];
    bit [RomLenBits-1:0] rom_len;
    bit [1:0]            step_tbl [4][4];
    bit                  phase1;
    state_e              seq;
    bit [8:0]            dblock;
    bit [4:0]            doff;
    bit [11:0]           ctrl_addr;
    bit                  stop_f, voiced_f, silence_f;
    bit [6:0]            len_cnt;
    bit [1:0]            rep_reload;
    bit [1:0]            prev_delta;
    bit [3:0]            level;
    bit [11:0]           fetch;
    bit                  busy;
    bit [5:0]            word;
    bit                  cy_off, cy_quarter, cy_repeat, cy_length;
    dac_beat_t           owed_beats[$];
    int                  errors;
    int                  checked;

    function new();
      step_tbl = '{'{3, 3, 1, 1}, '{1, 1, 0, 0}, '{0, 0, 1, 1}, '{1, 1, 3, 3}};
      rom_len  = RomLenBits'(RomDepth);
      errors   = 0;
      checked  = 0;
      clear_regs();
    endfunction

    function void clear_regs();
      phase1     = 1'b0;
      seq        = ST_IDLE;
      dblock     = '0;
      doff       = '0;
      ctrl_addr  = '0;
      stop_f     = 1'b0;
      voiced_f   = 1'b0;
      silence_f  = 1'b0;
      len_cnt    = '0;
      rep_reload = '0;
      prev_delta = '0;
      level      = LevelMid;
      fetch      = '0;
      busy       = 1'b0;
      word       = '0;
      cy_off     = 1'b0;
      cy_quarter = 1'b0;
      cy_repeat  = 1'b0;
      cy_length  = 1'b0;
    endfunction

    function void set_rom_length(bit [RomLenBits-1:0] len);
      rom_len = len;
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction

    function bit [7:0] rom_rd(bit [11:0] addr);
      if ({1'b0, addr} >= rom_len) return 8'h00;
      return rom_img[addr];
    endfunction

    function bit [11:0] blk_addr(bit [4:0] off);
      return {dblock, off[4:2]};
    endfunction

    // One delta sample through the integrator, then the counter and fetch updates.
    function void play_delta();
      bit [1:0] quarter, sel, delta, old;
      bit       period_start, mirror, add;
      bit [7:0] data;
      bit [4:0] a;
      int       inc, lv;
      quarter      = len_cnt[1:0];
      period_start = (doff == 5'd0);
      mirror       = voiced_f && quarter[0];
      sel          = doff[1:0];
      if (mirror) sel = sel ^ 2'd3;
      data  = rom_rd(fetch);
      delta = 2'((data >> ((3 - sel) * 2)) & 8'd3);
      old   = prev_delta;
      if (quarter == 2'd0 && period_start) old = 2'd2;
      if (!mirror) begin
        inc = step_tbl[delta][old];
        add = (delta >= 2'd2);
      end else begin
        inc = step_tbl[old][delta];
        add = (old < 2'd2);
      end
      prev_delta = delta;
      if (mirror && period_start) inc = 0;

      if (silence_f || (voiced_f && quarter[1])) begin
        level = LevelMid;
      end else begin
        lv = level;
        if (quarter == 2'd0 && period_start) lv = 7;
        if (!add) lv = lv ^ 15;
        lv = lv + inc;
        if (lv > 15) lv = 15;
        if (!add) lv = lv ^ 15;
        level = 4'(lv);
      end

      doff = doff + 5'd1;
      if (cy_off) begin
        doff    = '0;
        len_cnt = len_cnt + 7'd1;
      end
      if (voiced_f && cy_repeat) begin
        len_cnt = {len_cnt[6:4], rep_reload, 2'b00};
        dblock  = dblock + 9'd1;
      end
      if (!voiced_f && cy_off) dblock = dblock + 9'd1;

      a = doff;
      if (voiced_f && len_cnt[0]) a = a ^ 5'h1F;
      fetch = blk_addr(a);

      if (stop_f && cy_length) begin
        seq = ST_END;
      end else if (cy_length) begin
        seq   = ST_BLOCK;
        fetch = ctrl_addr;
      end else begin
        seq = ST_PLAY;
      end
    endfunction

    function void advance_phase();
      bit [7:0] b;
      if (phase1) begin
        phase1     = 1'b0;
        cy_off     = (doff == 5'h1F);
        cy_quarter = cy_off && (len_cnt[1:0] == 2'd3);
        cy_repeat  = cy_quarter && (len_cnt[3:2] == 2'd3);
        cy_length  = cy_repeat && (len_cnt == 7'h7F);
        return;
      end
      phase1 = 1'b1;
      case (seq)
        ST_IDLE: begin
          level = LevelMid;
          busy  = 1'b0;
        end
        ST_WORD: begin
          dblock = 9'(word[5:2]);
          doff   = {word[1:0], 3'b000};
          fetch  = blk_addr(doff);
          level  = LevelMid;
          busy   = 1'b1;
          seq    = ST_CADDR_HI;
        end
        ST_CADDR_HI: begin
          ctrl_addr = {rom_rd(fetch), 4'h0};
          doff      = doff + 5'd4;
          fetch     = blk_addr(doff);
          level     = LevelMid;
          seq       = ST_CADDR_LO;
        end
        ST_CADDR_LO: begin
          b              = rom_rd(fetch);
          ctrl_addr[3:0] = b[7:4];
          fetch          = ctrl_addr;
          level          = LevelMid;
          seq            = ST_BLOCK;
        end
        ST_BLOCK: begin
          dblock    = {rom_rd(fetch), 1'b0};
          doff      = '0;
          ctrl_addr = ctrl_addr + 12'd1;
          fetch     = ctrl_addr;
          level     = LevelMid;
          seq       = ST_CTRL;
        end
        ST_CTRL: begin
          b          = rom_rd(fetch);
          stop_f     = b[7];
          voiced_f   = b[6];
          silence_f  = b[5];
          rep_reload = b[1:0];
          len_cnt    = {b[4:0], 2'b00};
          doff       = '0;
          ctrl_addr  = ctrl_addr + 12'd1;
          fetch      = blk_addr(5'd0);
          level      = LevelMid;
          seq        = ST_PLAY;
        end
        ST_PLAY: play_delta();
        default: begin
          level = LevelMid;
          seq   = ST_IDLE;
        end
      endcase
    endfunction

    // Called for every accepted input beat.
    function void note_beat(action_e act, bit [11:0] addr, bit [7:0] data, bit [5:0] wnum);
      dac_beat_t beat;
      case (act)
        ACT_LOAD: rom_img[addr] = data;
        ACT_START: begin
          clear_regs();
          word = wnum;
          seq  = ST_WORD;
        end
        ACT_TICK: begin
          advance_phase();
          beat.level    = level;
          beat.busy     = busy;
          beat.finished = (seq == ST_IDLE) && !busy;
          owed_beats    = {owed_beats, beat};
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      errors++;
      if (errors <= 30) $display("[%0t ns] %s", $realtime, what);
    endtask

    // Called for every accepted result beat.
    task check_beat(logic [3:0] lv, logic bz, logic fin);
      dac_beat_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("result with nothing owed: level %0d busy %b finished %b",
                         lv, bz, fin));
        return;
      end
      want = owed_beats.pop_front();
      checked++;
      if (lv !== want.level)
        report($sformatf("beat %0d level %0d, want %0d", checked, lv, want.level));
      if (bz !== want.busy)
        report($sformatf("beat %0d busy %b, want %b", checked, bz, want.busy));
      if (fin !== want.finished)
        report($sformatf("beat %0d finished %b, want %b", checked, fin, want.finished));
    endtask
  endclass

  // Generous bound: every beat with a full sender gap, its tick update cycle and a full stall.
  localparam int CycleLimit = 600_000;

  // Only the low part of the ROM is loaded; the window never reaches past it,
  // so every read either hits a loaded byte or lands outside the window.
  localparam int FillBytes = 512;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [RomLenBits-1:0] cfg_wdata = '0;

  dms_in_if  item_bus ();
  dms_out_if result_bus ();

  delta_modulation_speech_sequencer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_bus),
    .result_o    (result_bus)
  );

  speech_tracker tracker = new();

  bit idling_on   = 1'b1;   // random gaps on both sides; cleared for the final stretch
  int stall_left  = 0;
  int cycle_count = 0;
  int n_loads     = 0;
  int n_starts    = 0;
  int n_ticks     = 0;
  int n_settings  = 0;

  always #6 clk_i = ~clk_i;

  // Watchdog: a stuck handshake or a dropped result ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("delta_modulation_speech_sequencer_top: mismatch");
      $finish;
    end
  end

  // Result side back-pressure: ready drops in bursts of random length.
  always @(posedge clk_i) begin
    if (idling_on && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 9);
    if (!idling_on) stall_left = 0;
    if (stall_left != 0) begin
      stall_left--;
      result_bus.ready <= 1'b0;
    end else begin
      result_bus.ready <= 1'b1;
    end
  end

  // Every result beat goes through the tracker; sampled at the edge, before updates land.
  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
      tracker.check_beat(result_bus.level, result_bus.busy_res, result_bus.finished);
  end

  // Drive one input beat; an optional gap first, then hold valid until it is taken.
  task automatic send_beat(input action_e act, input logic [11:0] addr,
                           input logic [7:0] data, input logic [5:0] wnum);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    item_bus.valid        <= 1'b1;
    item_bus.action       <= act;
    item_bus.load_address <= addr;
    item_bus.load_byte    <= data;
    item_bus.word_number  <= wnum;
    do @(posedge clk_i); while (item_bus.ready !== 1'b1);
    tracker.note_beat(act, addr, data, wnum);
    case (act)
      ACT_LOAD:  n_loads++;
      ACT_START: n_starts++;
      ACT_TICK:  n_ticks++;
      default: ;
    endcase
  endtask

  // Unused fields of ticks and starts carry junk so every input bit toggles.
  task automatic send_tick();
    send_beat(ACT_TICK, 12'($urandom), 8'($urandom), 6'($urandom));
  endtask

  task automatic send_start(input logic [5:0] wnum);
    send_beat(ACT_START, 12'($urandom), 8'($urandom), wnum);
  endtask

  // Stop sending and wait for the block to hand back everything it owes.
  // Loads and starts give no beat, so the task waits on past the last owed beat to let the last one land.
  task automatic settle();
    item_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_rom_length(input logic [RomLenBits-1:0] len);
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    tracker.set_rom_length(len);
    n_settings++;
  endtask

  // Mostly ticks so words play through their frames; now and then a restart,
  // a ROM rewrite, or a beat with the unused action code.
  task automatic run_stream(input int beats);
    int sent;
    int pick;
    sent = 0;
    send_start(6'($urandom));
    while (sent < beats) begin
      pick = $urandom_range(0, 299);
      if (pick == 0) begin
        send_start(6'($urandom));
        sent++;
      end else if (pick < 6) begin
        send_beat(ACT_LOAD, 12'($urandom), 8'($urandom), 6'($urandom));
        sent++;
      end else if (pick < 8) begin
        send_beat(ACT_NONE, 12'($urandom), 8'($urandom), 6'($urandom));
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    bit [7:0]            plan [RomDepth];
    bit [11:0]           caddr;
    bit [7:0]            ctl;
    int                  nfr;
    logic [RomLenBits-1:0] len_set [4];
    int                  len_beats [4];

    item_bus.valid        = 1'b0;
    item_bus.action       = ACT_NONE;
    item_bus.load_address = '0;
    item_bus.load_byte    = '0;
    item_bus.word_number  = '0;
    result_bus.ready      = 1'b0;

    // Phrase ROM layout: word pointers at 2w / 2w+1, frame lists of
    // (block byte, control byte) pairs from 0x080, six bytes per word,
    // delta data random everywhere.
    foreach (plan[i]) plan[i] = 8'($urandom);
    for (int w = 0; w < 64; w++) begin
      caddr = 12'h080 + 12'(w * 6);
      plan[2 * w]     = caddr[11:4];
      plan[2 * w + 1] = {caddr[3:0], 4'($urandom)};
      nfr = $urandom_range(1, 3);
      for (int f = 0; f < nfr; f++) begin
        ctl    = 8'($urandom);
        ctl[7] = (f == nfr - 1);
        // Short frames keep a word near a thousand ticks; voiced frames
        // sometimes take the repeat reload path.
        if (ctl[6] && $urandom_range(0, 2) == 0) ctl[4:0] = 5'h1B;
        else if ($urandom_range(0, 3) == 0)      ctl[4:0] = 5'h1E;
        else                                     ctl[4:0] = 5'h1F;
        plan[caddr + 1] = ctl;
        caddr = caddr + 12'd2;
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The loaded part is written before any word can read it; the window
    // is then closed down to it.
    for (int i = 0; i < FillBytes; i++)
      send_beat(ACT_LOAD, 12'(i), plan[i], 6'($urandom));
    settle();
    write_rom_length(RomLenBits'(FillBytes));

    // Directed: ignored action, ticks while idle, lowest and highest word numbers.
    send_beat(ACT_NONE, 12'hFFF, 8'hFF, 6'h3F);
    send_tick();
    send_tick();
    send_start(6'd0);
    repeat (8) send_tick();
    send_start(6'd63);
    repeat (12) send_tick();
    settle();

    // Random playback under several ROM windows: full loaded part, empty,
    // partial, then full again with no gaps on either side.
    len_set   = '{RomLenBits'(FillBytes), 13'd0,
                  RomLenBits'($urandom_range(1, FillBytes - 1)), RomLenBits'(FillBytes)};
    len_beats = '{200, 40, 120, 152};
    for (int p = 0; p < 4; p++) begin
      write_rom_length(len_set[p]);
      if (p == 3) idling_on = 1'b0;
      run_stream(len_beats[p]);
      settle();
    end
    repeat (8) @(posedge clk_i);

    $display("run: %0d ROM loads, %0d word starts, %0d ticks (%0d results checked)",
             n_loads, n_starts, n_ticks, tracker.checked);
    $display("run: %0d ROM window settings incl. empty, partial and full", n_settings);
    if (tracker.errors == 0) begin
      $display("delta_modulation_speech_sequencer_top: match");
    end else begin
      $display("delta_modulation_speech_sequencer_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== delta_modulation_speech_sequencer_top.f =====
sv/dms_pkg.sv
sv/dms_if.sv
sv/dms_ram.sv
sv/delta_modulation_speech_sequencer_top.sv
tb/tb.sv
